### rtl/core/tomrs_pkg.sv
// ----------------------------------------------------------------------------
// Reservation station package
// Shared widths and the control group passed along the row of entry cells.
// ----------------------------------------------------------------------------
package tomrs_pkg;

  localparam int KIND_W = 6;
  localparam int FREE_W = 4;
  localparam int FREE_MAX = 15;

  // Search state rippled from the lowest cell to the highest.
  typedef struct packed {
    logic free_seen;
    logic ready_seen;
  } chain_ctl_t;

endpackage

### rtl/core/tomrs_cell.sv
// ----------------------------------------------------------------------------
// Reservation station entry cell
// Holds one entry, takes part in the lowest-free and lowest-ready searches,
// and snoops the two result buses for its operand tags.
// ----------------------------------------------------------------------------
module tomrs_cell #(
  parameter int DW    = 32,
  parameter int ROB_W = 5,
  parameter int TAG_W = 6,
  parameter int CW    = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        flush,
  input  logic                        disp_valid,
  input  logic [tomrs_pkg::KIND_W-1:0] disp_kind,
  input  logic [DW-1:0]               disp_first_value,
  input  logic [DW-1:0]               disp_second_value,
  input  logic [TAG_W-1:0]            disp_first_tag,
  input  logic [TAG_W-1:0]            disp_second_tag,
  input  logic [ROB_W-1:0]            disp_rob,
  input  logic [TAG_W-1:0]            alu_tag,
  input  logic [DW-1:0]               alu_value,
  input  logic [TAG_W-1:0]            mem_tag,
  input  logic [DW-1:0]               mem_value,
  input  tomrs_pkg::chain_ctl_t       ctl_in,
  output tomrs_pkg::chain_ctl_t       ctl_out,
  input  logic [CW-1:0]               cnt_in,
  output logic [CW-1:0]               cnt_out,
  input  logic [tomrs_pkg::KIND_W-1:0] pay_kind_in,
  output logic [tomrs_pkg::KIND_W-1:0] pay_kind_out,
  input  logic [DW-1:0]               pay_first_in,
  output logic [DW-1:0]               pay_first_out,
  input  logic [DW-1:0]               pay_second_in,
  output logic [DW-1:0]               pay_second_out,
  input  logic [ROB_W-1:0]            pay_rob_in,
  output logic [ROB_W-1:0]            pay_rob_out
);

  logic                         busy;
  logic [tomrs_pkg::KIND_W-1:0] kind;
  logic [DW-1:0]                first_value;
  logic [DW-1:0]                second_value;
  logic                         first_rdy;
  logic                         second_rdy;
  logic [ROB_W-1:0]             first_tag;
  logic [ROB_W-1:0]             second_tag;
  logic [ROB_W-1:0]             rob;

  logic my_free;
  logic my_ready;
  logic alloc;
  logic pick;
  logic alu_on;
  logic mem_on;
  logic alu_hit1;
  logic alu_hit2;
  logic mem_hit1;
  logic mem_hit2;

  assign my_free  = !busy;
  assign my_ready = busy && first_rdy && second_rdy;
  assign alloc    = disp_valid && my_free && !ctl_in.free_seen;
  assign pick     = my_ready && !ctl_in.ready_seen;

  assign ctl_out.free_seen  = ctl_in.free_seen | my_free;
  assign ctl_out.ready_seen = ctl_in.ready_seen | my_ready;
  assign cnt_out = cnt_in + CW'(my_free);

  assign pay_kind_out   = pick ? kind : pay_kind_in;
  assign pay_first_out  = pick ? first_value : pay_first_in;
  assign pay_second_out = pick ? second_value : pay_second_in;
  assign pay_rob_out    = pick ? rob : pay_rob_in;

  // A negative bus tag means no broadcast; a ready operand never matches.
  assign alu_on   = !alu_tag[TAG_W-1];
  assign mem_on   = !mem_tag[TAG_W-1];
  assign alu_hit1 = alu_on && !first_rdy && (first_tag == alu_tag[ROB_W-1:0]);
  assign alu_hit2 = alu_on && !second_rdy && (second_tag == alu_tag[ROB_W-1:0]);
  assign mem_hit1 = mem_on && !first_rdy && (first_tag == mem_tag[ROB_W-1:0]);
  assign mem_hit2 = mem_on && !second_rdy && (second_tag == mem_tag[ROB_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (step) begin
      if (flush) begin
        busy <= 1'b0;
      end else if (alloc) begin
        busy <= 1'b1;
      end else if (pick) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !flush) begin
      if (alloc) begin
        kind         <= disp_kind;
        first_value  <= disp_first_value;
        second_value <= disp_second_value;
        first_rdy    <= disp_first_tag[TAG_W-1];
        second_rdy   <= disp_second_tag[TAG_W-1];
        first_tag    <= disp_first_tag[ROB_W-1:0];
        second_tag   <= disp_second_tag[ROB_W-1:0];
        rob          <= disp_rob;
      end else if (busy) begin
        // The ALU bus wins when both buses carry the same tag.
        if (alu_hit1) begin
          first_value <= alu_value;
          first_rdy   <= 1'b1;
        end else if (mem_hit1) begin
          first_value <= mem_value;
          first_rdy   <= 1'b1;
        end
        if (alu_hit2) begin
          second_value <= alu_value;
          second_rdy   <= 1'b1;
        end else if (mem_hit2) begin
          second_value <= mem_value;
          second_rdy   <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/tomasulo_reservation_station.sv
// ----------------------------------------------------------------------------
// Tomasulo reservation station
// Each beat is one processor cycle: flush, dispatch, two result broadcasts.
// ----------------------------------------------------------------------------
// The station takes one beat per clock and returns exactly one result beat
// for it in the next cycle, through an output register. The next beat is
// taken at the same edge at which the previous result is taken; while a
// result waits unaccepted, the input stalls. Entries sit in a row of
// identical cells. The lowest-free and lowest-ready searches, the free count
// and the issue payload ripple unregistered through that row, so the longest
// path grows with STATION_ENTRIES. Every decision uses the entries as they
// stood before the beat; a flush clears all entries and issues nothing.
module tomasulo_reservation_station #(
  parameter int STATION_ENTRIES = 8,
  parameter int ROB_ENTRIES     = 32,
  parameter int DATA_WIDTH      = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // From bit 0: flush, dispatch_valid, dispatch_kind, dispatch_first_value,
  // dispatch_second_value, dispatch_first_tag, dispatch_second_tag,
  // dispatch_rob, alu_tag, alu_value, mem_tag, mem_value, zero fill.
  input  logic [((2 + tomrs_pkg::KIND_W + 4 * DATA_WIDTH + 4 * ($clog2(ROB_ENTRIES) + 1)
                 + $clog2(ROB_ENTRIES) + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // From bit 0: issue_valid, issue_kind, issue_first, issue_second,
  // issue_rob, free_entries, overflow, zero fill.
  output logic [((2 + tomrs_pkg::KIND_W + 2 * DATA_WIDTH + $clog2(ROB_ENTRIES)
                  + tomrs_pkg::FREE_W + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int DW     = DATA_WIDTH;
  localparam int KW     = tomrs_pkg::KIND_W;
  localparam int ROB_W  = $clog2(ROB_ENTRIES);
  localparam int TAG_W  = ROB_W + 1;
  localparam int CW     = $clog2(STATION_ENTRIES + 1);
  localparam int FW     = tomrs_pkg::FREE_W;

  localparam int I_KIND = 2;
  localparam int I_V1   = I_KIND + KW;
  localparam int I_V2   = I_V1 + DW;
  localparam int I_T1   = I_V2 + DW;
  localparam int I_T2   = I_T1 + TAG_W;
  localparam int I_ROB  = I_T2 + TAG_W;
  localparam int I_AT   = I_ROB + ROB_W;
  localparam int I_AV   = I_AT + TAG_W;
  localparam int I_MT   = I_AV + DW;
  localparam int I_MV   = I_MT + TAG_W;

  localparam int O_BITS = 2 + KW + 2 * DW + ROB_W + FW;
  localparam int O_TW   = ((O_BITS + 7) / 8) * 8;

  logic                flush;
  logic                disp_valid;
  logic [KW-1:0]       disp_kind;
  logic [DW-1:0]       disp_first_value;
  logic [DW-1:0]       disp_second_value;
  logic [TAG_W-1:0]    disp_first_tag;
  logic [TAG_W-1:0]    disp_second_tag;
  logic [ROB_W-1:0]    disp_rob;
  logic [TAG_W-1:0]    alu_tag;
  logic [DW-1:0]       alu_value;
  logic [TAG_W-1:0]    mem_tag;
  logic [DW-1:0]       mem_value;

  logic                step;

  tomrs_pkg::chain_ctl_t ctl     [0:STATION_ENTRIES];
  logic [CW-1:0]         cnt     [0:STATION_ENTRIES];
  logic [KW-1:0]         p_kind  [0:STATION_ENTRIES];
  logic [DW-1:0]         p_first [0:STATION_ENTRIES];
  logic [DW-1:0]         p_second[0:STATION_ENTRIES];
  logic [ROB_W-1:0]      p_rob   [0:STATION_ENTRIES];

  logic                  res_issue;
  logic [FW-1:0]         res_free;
  logic                  res_overflow;
  logic [O_BITS-1:0]     res_bits;
  logic [O_BITS-1:0]     out_bits;

  assign flush             = s_axis_tdata[0];
  assign disp_valid        = s_axis_tdata[1];
  assign disp_kind         = s_axis_tdata[I_KIND +: KW];
  assign disp_first_value  = s_axis_tdata[I_V1 +: DW];
  assign disp_second_value = s_axis_tdata[I_V2 +: DW];
  assign disp_first_tag    = s_axis_tdata[I_T1 +: TAG_W];
  assign disp_second_tag   = s_axis_tdata[I_T2 +: TAG_W];
  assign disp_rob          = s_axis_tdata[I_ROB +: ROB_W];
  assign alu_tag           = s_axis_tdata[I_AT +: TAG_W];
  assign alu_value         = s_axis_tdata[I_AV +: DW];
  assign mem_tag           = s_axis_tdata[I_MT +: TAG_W];
  assign mem_value         = s_axis_tdata[I_MV +: DW];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  assign ctl[0].free_seen  = 1'b0;
  assign ctl[0].ready_seen = 1'b0;
  assign cnt[0]      = '0;
  assign p_kind[0]   = '0;
  assign p_first[0]  = '0;
  assign p_second[0] = '0;
  assign p_rob[0]    = '0;

  for (genvar g = 0; g < STATION_ENTRIES; g++) begin : g_cell
    tomrs_cell #(
      .DW   (DW),
      .ROB_W(ROB_W),
      .TAG_W(TAG_W),
      .CW   (CW)
    ) u_cell (
      .clk              (clk),
      .rst              (rst),
      .step             (step),
      .flush            (flush),
      .disp_valid       (disp_valid),
      .disp_kind        (disp_kind),
      .disp_first_value (disp_first_value),
      .disp_second_value(disp_second_value),
      .disp_first_tag   (disp_first_tag),
      .disp_second_tag  (disp_second_tag),
      .disp_rob         (disp_rob),
      .alu_tag          (alu_tag),
      .alu_value        (alu_value),
      .mem_tag          (mem_tag),
      .mem_value        (mem_value),
      .ctl_in           (ctl[g]),
      .ctl_out          (ctl[g+1]),
      .cnt_in           (cnt[g]),
      .cnt_out          (cnt[g+1]),
      .pay_kind_in      (p_kind[g]),
      .pay_kind_out     (p_kind[g+1]),
      .pay_first_in     (p_first[g]),
      .pay_first_out    (p_first[g+1]),
      .pay_second_in    (p_second[g]),
      .pay_second_out   (p_second[g+1]),
      .pay_rob_in       (p_rob[g]),
      .pay_rob_out      (p_rob[g+1])
    );
  end

  // The free count reports the state before the beat and saturates.
  assign res_free = (32'(cnt[STATION_ENTRIES]) > 32'(tomrs_pkg::FREE_MAX))
                  ? FW'(tomrs_pkg::FREE_MAX) : FW'(cnt[STATION_ENTRIES]);
  assign res_issue    = !flush && ctl[STATION_ENTRIES].ready_seen;
  assign res_overflow = !flush && disp_valid && !ctl[STATION_ENTRIES].free_seen;

  // A flush sends zeros in place of the issued entry.
  assign res_bits = flush
                  ? {res_overflow, res_free, {(O_BITS - 1 - FW){1'b0}}}
                  : {res_overflow, res_free, p_rob[STATION_ENTRIES],
                     p_second[STATION_ENTRIES], p_first[STATION_ENTRIES],
                     p_kind[STATION_ENTRIES], res_issue};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_bits <= res_bits;
    end
  end

  assign m_axis_tdata = {{(O_TW - O_BITS){1'b0}}, out_bits};

endmodule

### bench/tomasulo_reservation_station_tb.sv
// ----------------------------------------------------------------------------
// Reservation station testbench
// Drives processor-cycle beats into the station and checks every issue beat
// against a cycle-level prediction of the entries, under varied stalls.
// ----------------------------------------------------------------------------
module tomasulo_reservation_station_tb;

  localparam int STATIONS = 8;
  localparam int IN_W = 168;
  localparam int OUT_W = 88;
  localparam int PHASE_ITEMS = 475;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [5:0] tag_t;
  typedef logic [tomrs_pkg::KIND_W-1:0] kind_t;
  typedef logic [tomrs_pkg::FREE_W-1:0] free_t;
  typedef logic [4:0] rob_t;
  localparam tag_t NO_TAG = 6'h3F;

  typedef struct packed {
    logic [2:0] fill;
    logic [31:0] mem_value;
    tag_t mem_tag;
    logic [31:0] alu_value;
    tag_t alu_tag;
    rob_t dispatch_rob;
    tag_t dispatch_second_tag;
    tag_t dispatch_first_tag;
    logic [31:0] dispatch_second_value;
    logic [31:0] dispatch_first_value;
    kind_t dispatch_kind;
    logic dispatch_valid;
    logic flush;
  } cycle_beat_t;

  typedef struct packed {
    logic [6:0] fill;
    logic overflow;
    free_t free_entries;
    rob_t issue_rob;
    logic [31:0] issue_second;
    logic [31:0] issue_first;
    kind_t issue_kind;
    logic issue_valid;
  } issue_beat_t;

  class issue_scoreboard;
    bit busy [STATIONS];
    bit [tomrs_pkg::KIND_W-1:0] kind [STATIONS];
    bit [31:0] first_val [STATIONS];
    bit [31:0] second_val [STATIONS];
    bit [5:0] first_tag [STATIONS];
    bit [5:0] second_tag [STATIONS];
    bit [4:0] rob [STATIONS];
    issue_beat_t expected_q [$];
    int errors;

    // Predicts the issue beat of one cycle and advances the entries.
    function void note_beat(cycle_beat_t b);
      bit old_busy [STATIONS];
      bit [5:0] old_first [STATIONS];
      bit [5:0] old_second [STATIONS];
      issue_beat_t want;
      int free_count;
      int slot;
      int pick;
      tag_t bus_tag [2];
      logic [31:0] bus_val [2];
      old_busy = busy;
      old_first = first_tag;
      old_second = second_tag;
      free_count = 0;
      slot = -1;
      pick = -1;
      for (int i = 0; i < STATIONS; i++) begin
        if (!old_busy[i]) begin
          free_count++;
          if (slot < 0) slot = i;
        end
      end
      want = '0;
      want.free_entries = free_t'((free_count > tomrs_pkg::FREE_MAX)
                                  ? tomrs_pkg::FREE_MAX : free_count);
      if (b.flush) begin
        foreach (busy[i]) busy[i] = 1'b0;
        expected_q.push_back(want);
        return;
      end
      for (int i = 0; i < STATIONS; i++) begin
        if (pick < 0 && old_busy[i] && old_first[i][5] && old_second[i][5]) pick = i;
      end
      if (pick >= 0) begin
        want.issue_valid = 1'b1;
        want.issue_kind = kind[pick];
        want.issue_first = first_val[pick];
        want.issue_second = second_val[pick];
        want.issue_rob = rob[pick];
      end
      // The memory bus is applied first so that the ALU value wins a tie.
      bus_tag[0] = b.mem_tag;
      bus_val[0] = b.mem_value;
      bus_tag[1] = b.alu_tag;
      bus_val[1] = b.alu_value;
      for (int k = 0; k < 2; k++) begin
        if (!bus_tag[k][5]) begin
          for (int i = 0; i < STATIONS; i++) begin
            if (old_busy[i]) begin
              if (old_first[i] == bus_tag[k]) begin
                first_val[i] = bus_val[k];
                first_tag[i] = NO_TAG;
              end
              if (old_second[i] == bus_tag[k]) begin
                second_val[i] = bus_val[k];
                second_tag[i] = NO_TAG;
              end
            end
          end
        end
      end
      if (pick >= 0) busy[pick] = 1'b0;
      if (b.dispatch_valid) begin
        if (slot < 0) begin
          want.overflow = 1'b1;
        end else begin
          busy[slot] = 1'b1;
          kind[slot] = b.dispatch_kind;
          first_val[slot] = b.dispatch_first_value;
          second_val[slot] = b.dispatch_second_value;
          first_tag[slot] = b.dispatch_first_tag[5] ? NO_TAG : b.dispatch_first_tag;
          second_tag[slot] = b.dispatch_second_tag[5] ? NO_TAG : b.dispatch_second_tag;
          rob[slot] = b.dispatch_rob;
        end
      end
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(issue_beat_t got);
      issue_beat_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none got %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("issue_valid", 32'(want.issue_valid), 32'(got.issue_valid));
      compare_field("issue_kind", 32'(want.issue_kind), 32'(got.issue_kind));
      compare_field("issue_first", want.issue_first, got.issue_first);
      compare_field("issue_second", want.issue_second, got.issue_second);
      compare_field("issue_rob", 32'(want.issue_rob), 32'(got.issue_rob));
      compare_field("free_entries", 32'(want.free_entries), 32'(got.free_entries));
      compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  issue_scoreboard sb = new;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  always #10 clk = ~clk;

  tomasulo_reservation_station dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Results are checked before the same edge's input is noted; the
  // station answers in the cycle after a beat at the earliest.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_beat(s_axis_tdata);
    end
  end

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat
  // has been taken.
  task automatic send_beat(input cycle_beat_t b);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  function automatic cycle_beat_t quiet_beat();
    cycle_beat_t b;
    b = '0;
    b.dispatch_first_tag = NO_TAG;
    b.dispatch_second_tag = NO_TAG;
    b.alu_tag = NO_TAG;
    b.mem_tag = NO_TAG;
    return b;
  endfunction

  // Small tag values dominate so that broadcasts often hit waiting operands.
  function automatic tag_t pick_tag(int none_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < none_pct) return NO_TAG;
    if (r < none_pct + 5) return {1'b1, 5'($urandom_range(0, 31))};
    if (r < 90) return tag_t'($urandom_range(0, 7));
    return tag_t'($urandom_range(0, 31));
  endfunction

  function automatic cycle_beat_t random_beat();
    cycle_beat_t b;
    b = '0;
    b.flush = ($urandom_range(0, 99) < 2);
    b.dispatch_valid = ($urandom_range(0, 99) < 75);
    b.dispatch_kind = kind_t'($urandom);
    b.dispatch_first_value = $urandom;
    b.dispatch_second_value = $urandom;
    b.dispatch_first_tag = pick_tag(35);
    b.dispatch_second_tag = pick_tag(35);
    b.dispatch_rob = rob_t'($urandom);
    b.alu_tag = pick_tag(40);
    b.alu_value = $urandom;
    b.mem_tag = ($urandom_range(0, 99) < 10) ? b.alu_tag : pick_tag(40);
    b.mem_value = $urandom;
    return b;
  endfunction

  task automatic run_directed();
    cycle_beat_t b;
    send_beat(quiet_beat());
    // Ready operands at the value extremes issue on the next cycle.
    b = quiet_beat();
    b.dispatch_valid = 1'b1;
    b.dispatch_kind = '1;
    b.dispatch_first_value = '1;
    b.dispatch_rob = '1;
    send_beat(b);
    send_beat(quiet_beat());
    // A broadcast in the dispatch cycle does not wake the new entry.
    b = quiet_beat();
    b.dispatch_valid = 1'b1;
    b.dispatch_second_value = '1;
    b.dispatch_first_tag = 6'd5;
    b.dispatch_second_tag = 6'd6;
    b.alu_tag = 6'd5;
    b.alu_value = 32'h1234_5678;
    send_beat(b);
    send_beat(quiet_beat());
    b = quiet_beat();
    b.alu_tag = 6'd5;
    b.alu_value = 32'hA5A5_A5A5;
    b.mem_tag = 6'd6;
    b.mem_value = 32'h5A5A_5A5A;
    send_beat(b);
    send_beat(quiet_beat());
    // Both buses carry one tag; the ALU value must win.
    b = quiet_beat();
    b.dispatch_valid = 1'b1;
    b.dispatch_first_tag = 6'd31;
    b.dispatch_second_tag = 6'd31;
    b.dispatch_rob = 5'd17;
    send_beat(b);
    b = quiet_beat();
    b.alu_tag = 6'd31;
    b.alu_value = 32'd1;
    b.mem_tag = 6'd31;
    b.mem_value = 32'd2;
    send_beat(b);
    // Any negative tag means ready at dispatch and no broadcast on a bus.
    b = quiet_beat();
    b.dispatch_valid = 1'b1;
    b.dispatch_kind = 6'd21;
    b.dispatch_first_value = 32'hDEAD_BEEF;
    b.dispatch_first_tag = 6'h20;
    b.dispatch_second_tag = 6'h3E;
    b.alu_tag = 6'h20;
    b.mem_tag = 6'h21;
    send_beat(b);
    send_beat(quiet_beat());
    // Fill every entry with waiting operands; the last dispatch overflows.
    for (int i = 0; i <= STATIONS; i++) begin
      b = quiet_beat();
      b.dispatch_valid = 1'b1;
      b.dispatch_kind = kind_t'(i);
      b.dispatch_first_value = 32'(i);
      b.dispatch_first_tag = 6'd9;
      b.dispatch_second_tag = 6'd10;
      b.dispatch_rob = rob_t'(i);
      send_beat(b);
    end
    b = quiet_beat();
    b.alu_tag = 6'd9;
    b.alu_value = 32'hFFFF_0000;
    b.mem_tag = 6'd10;
    b.mem_value = 32'h0000_FFFF;
    send_beat(b);
    send_beat(quiet_beat());
    // A flush drops its own dispatch and reports the count before it.
    b = quiet_beat();
    b.flush = 1'b1;
    b.dispatch_valid = 1'b1;
    send_beat(b);
    send_beat(quiet_beat());
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_requests++;
        end
        1: begin
          send_idle_pct = 64;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 64;
        end
        default: begin
          send_idle_pct = 26;
          recv_stall_pct = 26;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_beat(random_beat());
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/tomrs_pkg.sv
rtl/core/tomrs_cell.sv
rtl/core/tomasulo_reservation_station.sv
bench/tomasulo_reservation_station_tb.sv
